[hdl/ptrb_pkg.sv]
// ptrb_pkg: shared constants, arctangent table and sideband type for the
// pinhole target range and bearing pipeline. No dependencies.
package ptrb_pkg;

	localparam int ANGLE_ITERATIONS = 16;
	localparam int DIV_BITS         = 24;
	localparam int DIV_LAT          = DIV_BITS + 1;

	localparam logic signed [31:0] DEG90_Q16   = 32'sd5898240;
	localparam logic signed [31:0] BEARING_LIM = 32'sd46080;
	localparam logic [23:0]        RANGE_MAX   = 24'hFFFFFF;
	localparam logic signed [33:0] ROT_X0      = 34'sd1073741824;

	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_HORIZON = 2'd1;
	localparam logic [1:0] ST_VALID   = 2'd2;

	localparam logic [2:0] REG_HALF_H = 3'd0;
	localparam logic [2:0] REG_HALF_W = 3'd1;
	localparam logic [2:0] REG_FOC_Y  = 3'd2;
	localparam logic [2:0] REG_FOC_X  = 3'd3;
	localparam logic [2:0] REG_TILT   = 3'd4;
	localparam logic [2:0] REG_H_LOW  = 3'd5;
	localparam logic [2:0] REG_H_HIGH = 3'd6;
	localparam logic [2:0] REG_YAW    = 3'd7;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [16:0] bearing;
		logic               rzero;
		logic               sat;
	} side_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic signed [31:0] atan_q16(input int i);
		logic signed [31:0] r;
		unique case (i)
			0:  r = 32'sd2949120;
			1:  r = 32'sd1740967;
			2:  r = 32'sd919879;
			3:  r = 32'sd466945;
			4:  r = 32'sd234379;
			5:  r = 32'sd117304;
			6:  r = 32'sd58666;
			7:  r = 32'sd29335;
			8:  r = 32'sd14668;
			9:  r = 32'sd7334;
			10: r = 32'sd3667;
			11: r = 32'sd1833;
			12: r = 32'sd917;
			13: r = 32'sd458;
			14: r = 32'sd229;
			15: r = 32'sd115;
			16: r = 32'sd57;
			17: r = 32'sd29;
			18: r = 32'sd14;
			19: r = 32'sd7;
			20: r = 32'sd4;
			21: r = 32'sd2;
			22: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/ptrb_cordic_vec.sv]
// ptrb_cordic_vec: pipelined vectoring CORDIC, one iteration per stage,
// returns atan(y/x) in degrees Q16. Depends on ptrb_pkg.
module ptrb_cordic_vec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	output logic               out_valid,
	output logic signed [31:0] z_out
);

	localparam int N = ptrb_pkg::ANGLE_ITERATIONS;

	logic               v_sn [0:N];
	logic signed [31:0] x_sn [0:N];
	logic signed [31:0] y_sn [0:N];
	logic signed [31:0] z_sn [0:N];

	assign v_sn[0] = in_valid;
	assign x_sn[0] = x_in;
	assign y_sn[0] = y_in;
	assign z_sn[0] = 32'sd0;

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[i+1] <= 1'b0;
			end else if (en) begin
				v_sn[i+1] <= v_sn[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_sn[i] >= 0) begin
					x_sn[i+1] <= x_sn[i] + (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] - (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] + ptrb_pkg::atan_q16(i);
				end else begin
					x_sn[i+1] <= x_sn[i] - (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] + (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] - ptrb_pkg::atan_q16(i);
				end
			end
		end
	end

	assign out_valid = v_sn[N];
	assign z_out     = z_sn[N];

endmodule

[hdl/ptrb_cordic_rot.sv]
// ptrb_cordic_rot: pipelined rotation CORDIC from x = 2^30, one iteration per
// stage, gives unnormalized cos and sin of an angle in degrees Q16. Depends on ptrb_pkg.
module ptrb_cordic_rot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] z_in,
	output logic               out_valid,
	output logic signed [33:0] cos_out,
	output logic signed [33:0] sin_out
);

	localparam int N = ptrb_pkg::ANGLE_ITERATIONS;

	logic               v_sn [0:N];
	logic signed [33:0] x_sn [0:N];
	logic signed [33:0] y_sn [0:N];
	logic signed [31:0] z_sn [0:N];

	assign v_sn[0] = in_valid;
	assign x_sn[0] = ptrb_pkg::ROT_X0;
	assign y_sn[0] = 34'sd0;
	assign z_sn[0] = z_in;

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[i+1] <= 1'b0;
			end else if (en) begin
				v_sn[i+1] <= v_sn[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_sn[i] >= 0) begin
					x_sn[i+1] <= x_sn[i] - (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] + (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] - ptrb_pkg::atan_q16(i);
				end else begin
					x_sn[i+1] <= x_sn[i] + (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] - (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] + ptrb_pkg::atan_q16(i);
				end
			end
		end
	end

	assign out_valid = v_sn[N];
	assign cos_out   = x_sn[N];
	assign sin_out   = y_sn[N];

endmodule

[hdl/ptrb_div.sv]
// ptrb_div: pipelined restoring divider, overflow check then one quotient bit
// per stage; saturates to all ones when the quotient exceeds 24 bits. Depends on ptrb_pkg.
module ptrb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [46:0] num,
	input  logic [30:0] den,
	output logic        out_valid,
	output logic [23:0] quo
);

	localparam int B = ptrb_pkg::DIV_BITS;

	logic        v_sn   [0:B];
	logic        ovf_sn [0:B];
	logic [46:0] r_sn   [0:B];
	logic [30:0] d_sn   [0:B];
	logic [B-1:0] q_sn  [0:B];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn[0] <= 1'b0;
		end else if (en) begin
			v_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_sn[0] <= {8'd0, num} >= {den, 24'd0};
			r_sn[0]   <= num;
			d_sn[0]   <= den;
			q_sn[0]   <= '0;
		end
	end

	for (genvar k = 0; k < B; k++) begin : g_bit
		localparam int BI = B - 1 - k;
		logic [54:0] dsh;
		logic        ge;
		assign dsh = 55'(d_sn[k]) << BI;
		assign ge  = {8'd0, r_sn[k]} >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[k+1] <= 1'b0;
			end else if (en) begin
				v_sn[k+1] <= v_sn[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ovf_sn[k+1] <= ovf_sn[k];
				d_sn[k+1]   <= d_sn[k];
				r_sn[k+1]   <= ge ? (r_sn[k] - dsh[46:0]) : r_sn[k];
				q_sn[k+1]   <= q_sn[k] | (ge ? (B'(1) << BI) : '0);
			end
		end
	end

	assign out_valid = v_sn[B];
	assign quo       = ovf_sn[B] ? ptrb_pkg::RANGE_MAX : q_sn[B];

endmodule

[hdl/pinhole_target_range_bearing.sv]
// Range and bearing to a target seen by a pinhole camera: row angle, tilt,
// cotangent ranges for two heights, column bearing. Depends on ptrb_pkg and the
// ptrb_cordic_vec, ptrb_cordic_rot and ptrb_div pipelines.
//
// One result per input transfer, in order. The pipeline takes a new item every
// cycle while it is not held; it is built from the two CORDIC chains of one
// iteration per stage and the divider of one quotient bit per stage. The whole
// pipeline holds while a result waits in the output register and is not taken.
// Registers are written through cfg_we/cfg_index/cfg_data and must only change
// while the block is empty.
module pinhole_target_range_bearing (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // pixel_col[11:0], pixel_row[23:12]
	input  logic        s_tuser,  // pair_found
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // range_low[23:0], range_high[47:24], bearing[64:48], zero fill
	output logic [1:0]  m_tuser   // status
);

	localparam int N = ptrb_pkg::ANGLE_ITERATIONS;
	localparam int L = ptrb_pkg::DIV_LAT;

	logic [10:0] half_h_q, half_w_q;
	logic [15:0] foc_y_q, foc_x_q, h_low_q, h_high_q;
	logic signed [15:0] tilt_q, yaw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_h_q <= 11'd360;
			half_w_q <= 11'd640;
			foc_y_q  <= 16'd8702;
			foc_x_q  <= 16'd25997;
			tilt_q   <= 16'sd6016;
			h_low_q  <= 16'd4966;
			h_high_q <= 16'd7168;
			yaw_q    <= 16'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptrb_pkg::REG_HALF_H: half_h_q <= cfg_data[10:0];
				ptrb_pkg::REG_HALF_W: half_w_q <= cfg_data[10:0];
				ptrb_pkg::REG_FOC_Y:  foc_y_q  <= cfg_data;
				ptrb_pkg::REG_FOC_X:  foc_x_q  <= cfg_data;
				ptrb_pkg::REG_TILT:   tilt_q   <= cfg_data;
				ptrb_pkg::REG_H_LOW:  h_low_q  <= cfg_data;
				ptrb_pkg::REG_H_HIGH: h_high_q <= cfg_data;
				ptrb_pkg::REG_YAW:    yaw_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// stage 1: offsets and CORDIC seeds
	logic               v_s1, pair_s1;
	logic signed [31:0] xv_s1, yv_s1, xh_s1, yh_s1;
	logic signed [13:0] roff, coff;
	logic [15:0]        fy, fx;

	assign roff = $signed({2'b00, s_tdata[23:12]}) - $signed({3'b000, half_h_q});
	assign coff = $signed({2'b00, s_tdata[11:0]}) - $signed({3'b000, half_w_q});
	assign fy   = (foc_y_q == 16'd0) ? 16'd1 : foc_y_q;
	assign fx   = (foc_x_q == 16'd0) ? 16'd1 : foc_x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= s_tuser;
			xv_s1   <= $signed({8'd0, fy, 8'd0});
			yv_s1   <= 32'(roff) <<< 12;
			xh_s1   <= $signed({8'd0, fx, 8'd0});
			yh_s1   <= 32'(coff) <<< 12;
		end
	end

	logic               vv_out, vh_out;
	logic signed [31:0] zv, zh;

	ptrb_cordic_vec u_vec_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.x_in(xv_s1), .y_in(yv_s1), .out_valid(vv_out), .z_out(zv)
	);

	ptrb_cordic_vec u_vec_h (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.x_in(xh_s1), .y_in(yh_s1), .out_valid(vh_out), .z_out(zh)
	);

	logic pair_sa [0:N];
	assign pair_sa[0] = pair_s1;
	for (genvar i = 0; i < N; i++) begin : g_sa
		always_ff @(posedge clk) begin
			if (en) pair_sa[i+1] <= pair_sa[i];
		end
	end

	// stage 2: net elevation, status, bearing
	logic signed [31:0] net, bq, bsh;
	logic signed [16:0] bcl;
	logic               pair_a;
	assign pair_a = pair_sa[N];
	assign net    = zv + (32'(tilt_q) <<< 8);
	assign bq     = zh - (32'(yaw_q) <<< 8);
	assign bsh    = (bq + 32'sd128) >>> 8;

	always_comb begin
		priority if (bsh > ptrb_pkg::BEARING_LIM) begin
			bcl = 17'(ptrb_pkg::BEARING_LIM);
		end else if (bsh < -ptrb_pkg::BEARING_LIM) begin
			bcl = 17'(-ptrb_pkg::BEARING_LIM);
		end else begin
			bcl = bsh[16:0];
		end
	end

	logic               v_s2;
	logic signed [31:0] net_s2;
	ptrb_pkg::side_t    side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= vv_out && vh_out;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			net_s2          <= net;
			side_s2.status  <= !pair_a ? ptrb_pkg::ST_NONE :
			                   (net <= 0) ? ptrb_pkg::ST_HORIZON : ptrb_pkg::ST_VALID;
			side_s2.bearing <= pair_a ? bcl : 17'sd0;
			side_s2.rzero   <= !pair_a || (net <= 0) || (net >= ptrb_pkg::DEG90_Q16);
			side_s2.sat     <= 1'b0;
		end
	end

	logic               vr_out;
	logic signed [33:0] cosv, sinv;

	ptrb_cordic_rot u_rot (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2), .z_in(net_s2),
		.out_valid(vr_out), .cos_out(cosv), .sin_out(sinv)
	);

	ptrb_pkg::side_t side_sb [0:N];
	assign side_sb[0] = side_s2;
	for (genvar i = 0; i < N; i++) begin : g_sb
		always_ff @(posedge clk) begin
			if (en) side_sb[i+1] <= side_sb[i];
		end
	end

	// stage 3: products and divider operands
	logic            v_s3;
	logic [46:0]     nlo_s3, nhi_s3;
	logic [30:0]     den_s3;
	ptrb_pkg::side_t side_s3;
	ptrb_pkg::side_t side_m;
	logic [30:0]     cos31;
	assign cos31 = cosv[30:0];

	always_comb begin
		side_m       = side_sb[N];
		side_m.rzero = side_sb[N].rzero || (cosv <= 0);
		side_m.sat   = (sinv <= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= vr_out;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nlo_s3  <= 47'(h_low_q) * 47'(cos31);
			nhi_s3  <= 47'(h_high_q) * 47'(cos31);
			den_s3  <= (sinv > 0) ? sinv[30:0] : 31'd1;
			side_s3 <= side_m;
		end
	end

	logic        vlo_out, vhi_out;
	logic [23:0] qlo, qhi;

	ptrb_div u_div_lo (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3), .num(nlo_s3),
		.den(den_s3), .out_valid(vlo_out), .quo(qlo)
	);

	ptrb_div u_div_hi (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3), .num(nhi_s3),
		.den(den_s3), .out_valid(vhi_out), .quo(qhi)
	);

	ptrb_pkg::side_t side_sc [0:L];
	assign side_sc[0] = side_s3;
	for (genvar i = 0; i < L; i++) begin : g_sc
		always_ff @(posedge clk) begin
			if (en) side_sc[i+1] <= side_sc[i];
		end
	end

	// output register
	ptrb_pkg::side_t so;
	logic [23:0]     rlo_q, rhi_q;
	logic signed [16:0] bear_q;
	logic [1:0]      status_q;
	assign so = side_sc[L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vlo_out && vhi_out;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= so.status;
			bear_q   <= so.bearing;
			rlo_q    <= so.rzero ? 24'd0 : so.sat ? ptrb_pkg::RANGE_MAX : qlo;
			rhi_q    <= so.rzero ? 24'd0 : so.sat ? ptrb_pkg::RANGE_MAX : qhi;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {7'd0, bear_q, rhi_q, rlo_q};

endmodule

[hdl/ptrb_checker.sv]
// ptrb_checker: port-level assertions for pinhole_target_range_bearing,
// bound to the top level. Depends on ptrb_pkg.
module ptrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ptrb_pkg::ST_NONE) |-> (m_tdata == 72'd0))
		else $error("no-target transfer carries data");

	a_horizon_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ptrb_pkg::ST_HORIZON) |-> (m_tdata[47:0] == 48'd0))
		else $error("below-horizon transfer carries a range");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ptrb_pkg::ST_NONE || m_tuser == ptrb_pkg::ST_HORIZON ||
		              m_tuser == ptrb_pkg::ST_VALID))
		else $error("status code out of range");

	a_bearing_lim: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[64:48]) <= 17'sd46080) &&
		             ($signed(m_tdata[64:48]) >= -17'sd46080))
		else $error("bearing beyond clamp");

endmodule

bind pinhole_target_range_bearing ptrb_checker u_ptrb_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);

[dv/tb_pinhole_target_range_bearing.sv]
// tb_pinhole_target_range_bearing: self-checking bench for the pinhole range and
// bearing pipeline. Drives directed and random transfers with random stalls on both
// sides, predicts each result in place and compares it field by field. Needs ptrb_pkg.
module tb_pinhole_target_range_bearing;

	localparam int LATENCY   = 61;
	localparam int CYCLE_CAP = 400000;

	typedef struct {
		logic [1:0]  status;
		logic [23:0] range_low;
		logic [23:0] range_high;
		logic [16:0] bearing;
	} estimate_t;

	typedef struct {
		logic [11:0] col;
		logic [11:0] row;
		logic        pair;
		logic        typed;
		estimate_t   want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	logic [15:0] cam_regs [8];
	estimate_t   pending_estimates [$];
	int          mismatches;
	int          results_seen;
	int          items_sent;
	int          n_valid, n_horizon, n_none;
	int          cycles;
	bit          hold_off_long;

	pinhole_target_range_bearing dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-v - 1) >>> s) - 1;
	endfunction

	function automatic longint atan_deg_q16(longint base, longint off);
		longint x, y, z, dx, dy;
		x = base * 256;
		y = off * 256;
		z = 0;
		for (int i = 0; i < ptrb_pkg::ANGLE_ITERATIONS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += ptrb_pkg::atan_q16(i);
			end else begin
				x -= dx; y += dy; z -= ptrb_pkg::atan_q16(i);
			end
		end
		return z;
	endfunction

	function automatic logic [23:0] cot_distance(longint h, longint c, longint s);
		longint q;
		if (c <= 0)
			return 24'd0;
		if (s <= 0)
			return ptrb_pkg::RANGE_MAX;
		q = (h * c) / s;
		return (q > 64'hFFFFFF) ? ptrb_pkg::RANGE_MAX : q[23:0];
	endfunction

	function automatic estimate_t estimate_target(logic [11:0] col, logic [11:0] row,
			logic pair);
		estimate_t e;
		longint fy, fx, net, x, y, z, dx, dy, b;
		e = '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0};
		if (!pair)
			return e;
		fy = (cam_regs[ptrb_pkg::REG_FOC_Y] == 0) ? 1 : cam_regs[ptrb_pkg::REG_FOC_Y];
		fx = (cam_regs[ptrb_pkg::REG_FOC_X] == 0) ? 1 : cam_regs[ptrb_pkg::REG_FOC_X];
		net = atan_deg_q16(fy, (longint'(row) - cam_regs[ptrb_pkg::REG_HALF_H]) * 16)
			+ longint'($signed(cam_regs[ptrb_pkg::REG_TILT])) * 256;
		if (net <= 0) begin
			e.status = ptrb_pkg::ST_HORIZON;
		end else begin
			e.status = ptrb_pkg::ST_VALID;
			if (net < ptrb_pkg::DEG90_Q16) begin
				x = 64'd1 << 30;
				y = 0;
				z = net;
				for (int i = 0; i < ptrb_pkg::ANGLE_ITERATIONS; i++) begin
					dx = floor_shift(y, i);
					dy = floor_shift(x, i);
					if (z >= 0) begin
						x -= dx; y += dy; z -= ptrb_pkg::atan_q16(i);
					end else begin
						x += dx; y -= dy; z += ptrb_pkg::atan_q16(i);
					end
				end
				e.range_low  = cot_distance(cam_regs[ptrb_pkg::REG_H_LOW], x, y);
				e.range_high = cot_distance(cam_regs[ptrb_pkg::REG_H_HIGH], x, y);
			end
		end
		b = atan_deg_q16(fx, (longint'(col) - cam_regs[ptrb_pkg::REG_HALF_W]) * 16)
			- longint'($signed(cam_regs[ptrb_pkg::REG_YAW])) * 256;
		b = floor_shift(b + 128, 8);
		if (b > ptrb_pkg::BEARING_LIM)
			b = ptrb_pkg::BEARING_LIM;
		if (b < -ptrb_pkg::BEARING_LIM)
			b = -ptrb_pkg::BEARING_LIM;
		e.bearing = b[16:0];
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ptrb_pkg::REG_HALF_H || idx == ptrb_pkg::REG_HALF_W)
			cam_regs[idx] = val & 16'h07FF;
		else
			cam_regs[idx] = val;
	endtask

	task automatic drain();
		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic send_item(logic [11:0] col, logic [11:0] row, logic pair,
			logic typed, estimate_t want);
		estimate_t e;
		e = estimate_target(col, row, pair);
		if (typed && e != want)
			report_mismatch("directed row", {col, row}, 0);
		s_tvalid <= 1'b1;
		s_tdata  <= {row, col};
		s_tuser  <= pair;
		do @(posedge clk); while (!s_tready);
		pending_estimates.insert(pending_estimates.size(), e);
		items_sent++;
	endtask

	task automatic sender_gap(bit allow);
		int g;
		if (!allow || $urandom_range(0, 2) == 0)
			return;
		g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		s_tvalid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int g;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_long) begin
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off_long = 1'b0;
			end
			if ($urandom_range(0, 3) == 0) begin
				g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_estimates.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				want = pending_estimates.pop_front();
				unique case (want.status)
					ptrb_pkg::ST_VALID:   n_valid++;
					ptrb_pkg::ST_HORIZON: n_horizon++;
					default:              n_none++;
				endcase
				if (m_tuser != want.status)
					report_mismatch("status", m_tuser, want.status);
				if (m_tdata[23:0] != want.range_low)
					report_mismatch("range_low", m_tdata[23:0], want.range_low);
				if (m_tdata[47:24] != want.range_high)
					report_mismatch("range_high", m_tdata[47:24], want.range_high);
				if (m_tdata[64:48] != want.bearing)
					report_mismatch("bearing", $signed(m_tdata[64:48]), $signed(want.bearing));
				if (m_tdata[71:65] != 7'd0)
					report_mismatch("zero fill", m_tdata[71:65], 0);
			end
		end
	end

	stim_row_t directed [] = '{
		'{12'd0,    12'd0,    1'b0, 1'b1, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd4095, 12'd4095, 1'b0, 1'b1, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd640,  12'd360,  1'b1, 1'b0, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd0,    12'd0,    1'b1, 1'b0, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd4095, 12'd4095, 1'b1, 1'b0, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd1280, 12'd720,  1'b1, 1'b0, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd640,  12'd2000, 1'b1, 1'b0, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd2730, 12'd1365, 1'b1, 1'b0, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd1365, 12'd2730, 1'b1, 1'b0, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}},
		'{12'd641,  12'd359,  1'b1, 1'b0, '{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0}}
	};

	task automatic run_random(int n, bit gaps);
		for (int i = 0; i < n; i++) begin
			sender_gap(gaps);
			send_item(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
				$urandom_range(0, 7) != 0, 1'b0,
				'{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0});
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic random_config();
		write_reg(ptrb_pkg::REG_HALF_H, 16'($urandom_range(0, 2047)));
		write_reg(ptrb_pkg::REG_HALF_W, 16'($urandom_range(0, 2047)));
		write_reg(ptrb_pkg::REG_FOC_Y, 16'($urandom_range(0, 65535)));
		write_reg(ptrb_pkg::REG_FOC_X, 16'($urandom_range(0, 65535)));
		write_reg(ptrb_pkg::REG_TILT, 16'($signed($urandom_range(0, 46080)) - 23040));
		write_reg(ptrb_pkg::REG_H_LOW, 16'($urandom_range(0, 65535)));
		write_reg(ptrb_pkg::REG_H_HIGH, 16'($urandom_range(0, 65535)));
		write_reg(ptrb_pkg::REG_YAW, 16'($signed($urandom_range(0, 46080)) - 23040));
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = 1'b0;
		mismatches    = 0;
		results_seen  = 0;
		items_sent    = 0;
		n_valid       = 0;
		n_horizon     = 0;
		n_none        = 0;
		hold_off_long = 1'b0;
		cam_regs      = '{16'd360, 16'd640, 16'd8702, 16'd25997,
			16'd6016, 16'd4966, 16'd7168, 16'd0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			sender_gap(1'b1);
			send_item(directed[i].col, directed[i].row, directed[i].pair,
				directed[i].typed, directed[i].want);
		end
		s_tvalid <= 1'b0;
		drain();

		// extremes: zero focal, max tilt/yaw, max heights
		write_reg(ptrb_pkg::REG_FOC_Y, 16'd0);
		write_reg(ptrb_pkg::REG_FOC_X, 16'd0);
		write_reg(ptrb_pkg::REG_TILT, 16'sd23040);
		write_reg(ptrb_pkg::REG_YAW, -16'sd23040);
		write_reg(ptrb_pkg::REG_H_LOW, 16'hFFFF);
		write_reg(ptrb_pkg::REG_H_HIGH, 16'hFFFF);
		write_reg(ptrb_pkg::REG_HALF_H, 16'd2047);
		write_reg(ptrb_pkg::REG_HALF_W, 16'd0);
		run_random(20, 1'b1);
		drain();

		// near horizon: tiny tilt, long focal, rows at and just past center
		write_reg(ptrb_pkg::REG_FOC_Y, 16'hFFFF);
		write_reg(ptrb_pkg::REG_FOC_X, 16'hFFFF);
		write_reg(ptrb_pkg::REG_TILT, 16'sd1);
		write_reg(ptrb_pkg::REG_YAW, 16'sd23040);
		write_reg(ptrb_pkg::REG_HALF_H, 16'd0);
		write_reg(ptrb_pkg::REG_HALF_W, 16'd2047);
		write_reg(ptrb_pkg::REG_H_LOW, 16'd0);
		write_reg(ptrb_pkg::REG_H_HIGH, 16'd1);
		for (int i = 0; i < 16; i++)
			send_item(12'($urandom_range(0, 4095)), i[11:0], 1'b1, 1'b0,
				'{ptrb_pkg::ST_NONE, 24'd0, 24'd0, 17'd0});
		s_tvalid <= 1'b0;
		drain();
		write_reg(ptrb_pkg::REG_TILT, -16'sd23040);

		// reset-like settings, long receiver hold-off while sender streams
		write_reg(ptrb_pkg::REG_HALF_H, 16'd360);
		write_reg(ptrb_pkg::REG_HALF_W, 16'd640);
		write_reg(ptrb_pkg::REG_FOC_Y, 16'd8702);
		write_reg(ptrb_pkg::REG_FOC_X, 16'd25997);
		write_reg(ptrb_pkg::REG_TILT, 16'd6016);
		write_reg(ptrb_pkg::REG_H_LOW, 16'd4966);
		write_reg(ptrb_pkg::REG_H_HIGH, 16'd7168);
		write_reg(ptrb_pkg::REG_YAW, 16'd0);
		hold_off_long = 1'b1;
		run_random(120, 1'b0);
		drain();

		for (int p = 0; p < 4; p++) begin
			random_config();
			run_random(90, 1'b1);
			drain();
		end

		$display("sent %0d items, checked %0d results over several register settings",
			items_sent, results_seen);
		$display("status mix: %0d valid, %0d below horizon, %0d no target",
			n_valid, n_horizon, n_none);
		if (mismatches == 0 && pending_estimates.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
